// ===== rtl/core/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared codes, types and report layout functions for the page report packer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Input function codes.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_PAGE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  // Report header and command bytes.
  localparam logic [7:0] HDR_CMD_DATA  = 8'h96;
  localparam logic [7:0] HDR_DATA      = 8'h95;
  localparam logic [7:0] HDR_SETUP     = 8'h94;
  localparam logic [7:0] HDR_RESET     = 8'h93;
  localparam logic [7:0] CMD_PAGE      = 8'hb8;
  localparam logic [7:0] CMD_COLUMN    = 8'h40;
  localparam logic [7:0] CMD_ONE       = 8'h01;
  localparam logic [7:0] CMD_TWO       = 8'h02;
  localparam logic [7:0] SETUP_DELAY   = 8'h64;
  localparam logic [7:0] SETUP_ON      = 8'h3F;
  localparam logic [7:0] SETUP_START   = 8'hC0;
  localparam logic [7:0] COLUMN_COUNT  = 8'h20;

  // Report lengths in bytes.
  localparam logic [5:0] LEN_PAGE_FIRST  = 6'd44;
  localparam logic [5:0] LEN_PAGE_SECOND = 6'd38;
  localparam logic [5:0] LEN_INIT_RESET  = 6'd3;
  localparam logic [5:0] LEN_INIT_SETUP  = 6'd9;

  // Index of the last report of each run.
  localparam logic [2:0] LAST_REP_PAGE = 3'd1;
  localparam logic [2:0] LAST_REP_INIT = 3'd4;

  // Position within a run, handed to the byte unit each fill cycle.
  typedef struct packed {
    logic       init;
    logic [2:0] rep;
    logic [5:0] pos;
    logic [1:0] cs;
    logic [2:0] page;
  } byte_sel_t;

  // What one report byte is: a constant or a column taken from the store.
  typedef struct packed {
    logic       is_col;
    logic [5:0] col;
    logic [7:0] value;
  } byte_req_t;

  function automatic logic [5:0] report_len(input logic init, input logic [2:0] rep);
    logic [5:0] len;
    if (init) begin
      len = (rep == 3'd0) ? LEN_INIT_RESET : LEN_INIT_SETUP;
    end else begin
      len = (rep == 3'd0) ? LEN_PAGE_FIRST : LEN_PAGE_SECOND;
    end
    return len;
  endfunction

  function automatic logic [2:0] last_rep(input logic init);
    return init ? LAST_REP_INIT : LAST_REP_PAGE;
  endfunction

  // Layout of every report byte.
  function automatic byte_req_t report_byte(input byte_sel_t sel);
    byte_req_t  r;
    logic [2:0] k;
    r = '0;
    k = sel.rep - 3'd1;
    if (sel.init) begin
      if (sel.rep == 3'd0) begin
        unique case (sel.pos)
          6'd0:    r.value = HDR_RESET;
          6'd1:    r.value = CMD_ONE;
          default: r.value = 8'h00;
        endcase
      end else begin
        unique case (sel.pos)
          6'd0:    r.value = HDR_SETUP;
          6'd1:    r.value = {4'b0000, k[1:0], 2'b00};
          6'd2:    r.value = CMD_TWO;
          6'd4:    r.value = SETUP_DELAY;
          6'd5:    r.value = SETUP_ON;
          6'd7:    r.value = SETUP_DELAY;
          6'd8:    r.value = SETUP_START;
          default: r.value = 8'h00;
        endcase
      end
    end else if (sel.rep == 3'd0) begin
      if (sel.pos >= 6'd12) begin
        r.is_col = 1'b1;
        r.col    = sel.pos - 6'd12;
      end else begin
        unique case (sel.pos)
          6'd0:    r.value = HDR_CMD_DATA;
          6'd1:    r.value = {4'b0000, sel.cs, 2'b00};
          6'd2:    r.value = CMD_TWO;
          6'd5:    r.value = CMD_PAGE | {5'b00000, sel.page};
          6'd8:    r.value = CMD_COLUMN;
          6'd11:   r.value = COLUMN_COUNT;
          default: r.value = 8'h00;
        endcase
      end
    end else begin
      if (sel.pos >= 6'd5 && sel.pos <= 6'd36) begin
        r.is_col = 1'b1;
        r.col    = sel.pos + 6'd27;
      end else begin
        unique case (sel.pos)
          6'd0:    r.value = HDR_DATA;
          6'd1:    r.value = {4'b0000, sel.cs, 2'b01};
          6'd4:    r.value = COLUMN_COUNT;
          default: r.value = 8'h00;
        endcase
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lpr_in_if.sv =====
// ----------------------------------------------------------------------------
// lpr_in_if
// Request channel: pixel writes, page emits and init requests.
// ----------------------------------------------------------------------------
interface lpr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pixel_x;
  logic [5:0] pixel_y;
  logic       pixel_on;

  modport source (output valid, output func, output pixel_x, output pixel_y,
                  output pixel_on, input ready);
  modport sink (input valid, input func, input pixel_x, input pixel_y,
                input pixel_on, output ready);
endinterface

// ===== rtl/core/lpr_out_if.sv =====
// ----------------------------------------------------------------------------
// lpr_out_if
// Report channel: one transfer per word of up to eight report bytes.
// ----------------------------------------------------------------------------
interface lpr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] report_word;
  logic [3:0]  word_bytes;
  logic        last_of_report;
  logic        last_of_run;

  modport source (output valid, output report_word, output word_bytes,
                  output last_of_report, output last_of_run, input ready);
  modport sink (input valid, input report_word, input word_bytes,
                input last_of_report, input last_of_run, output ready);
endinterface

// ===== rtl/core/lcd_page_report_packer.sv =====
// ----------------------------------------------------------------------------
// lcd_page_report_packer
// Holds a one-bit pixel store and packs pages of it into display reports.
//
//   channel  dir  payload                                       transfer
//   item     in   func, pixel_x, pixel_y, pixel_on              valid & ready
//   report   out  report_word, word_bytes, last_of_report,      valid & ready
//                 last_of_run
//
// A pixel write is a store read, then the modified byte is written back.
// Each report word is filled one byte per cycle through the single store
// read port, then passes through a drain state and a push state.
// Reset is synchronous and clears the page counter and control state; the
// pixel store is not cleared. A stalled report word holds the output register;
// the next word is assembled behind it and waits, and no further fill starts.
// ----------------------------------------------------------------------------
module lcd_page_report_packer #(
  parameter int DISPLAY_WIDTH  = 256,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  lpr_in_if.sink      item,
  lpr_out_if.source   report
);
  import lpr_pkg::*;

  localparam int DEPTH = DISPLAY_WIDTH * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = AW - 3;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WR_MOD = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_PUSH   = 3'd4;

  logic [2:0]    state;
  logic [4:0]    page_counter;
  logic          init_run;
  logic [2:0]    rep;
  logic [5:0]    pos;
  logic [2:0]    lane;
  logic [2:0]    lane_d;
  logic          byte_vld_d;
  logic [3:0]    word_fill;
  logic [63:0]   asm_word;

  logic [AW-1:0] wr_addr;
  logic [2:0]    wr_bit;
  logic          wr_on;

  logic          out_valid;
  logic [63:0]   out_word;
  logic [3:0]    out_bytes;
  logic          out_last_rep;
  logic          out_last_run;

  logic          accept;
  logic          wr_in_range;
  logic          wr_issue;
  logic [5:0]    cur_len;
  logic [5:0]    remaining;
  logic          word_end;
  logic          rep_end;
  logic          run_end;
  logic          load;

  byte_sel_t     sel;
  logic          bu_rd_en;
  logic [AW-1:0] bu_rd_addr;
  logic [7:0]    byte_data;

  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    bit_mask;

  // Handshake and run bookkeeping.
  always_comb begin
    item.ready  = (state == ST_IDLE);
    accept      = item.valid && item.ready;
    wr_in_range = ({1'b0, item.pixel_x} < 9'(DISPLAY_WIDTH))
                  && ({1'b0, item.pixel_y} < 7'(DISPLAY_HEIGHT));
    wr_issue    = accept && (item.func == FUNC_WRITE) && wr_in_range;
    cur_len     = report_len(init_run, rep);
    remaining   = cur_len - pos;
    word_end    = (lane == 3'd7) || (remaining == 6'd1);
    rep_end     = (pos == cur_len);
    run_end     = rep_end && (rep == last_rep(init_run));
    load        = !out_valid || report.ready;
  end

  // Position handed to the byte unit.
  always_comb begin
    sel.init = init_run;
    sel.rep  = rep;
    sel.pos  = pos;
    sel.cs   = page_counter[4:3];
    sel.page = page_counter[2:0];
  end

  lpr_byte_unit #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .AW             (AW)
  ) u_byte_unit (
    .clk       (clk),
    .issue     (state == ST_FILL),
    .sel       (sel),
    .rd_en     (bu_rd_en),
    .rd_addr   (bu_rd_addr),
    .rd_data   (ram_rdata),
    .byte_data (byte_data)
  );

  // Store port sharing: pixel writes and page fills never overlap.
  always_comb begin
    bit_mask  = 8'b1 << wr_bit;
    ram_we    = (state == ST_WR_MOD);
    ram_wdata = wr_on ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    ram_re    = wr_issue || bu_rd_en;
    ram_raddr = wr_issue ? {item.pixel_x[XW-1:0], item.pixel_y[5:3]} : bu_rd_addr;
  end

  lpr_pixel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer for pixel writes and report runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      page_counter <= 5'd0;
      byte_vld_d   <= 1'b0;
      init_run     <= 1'b0;
      rep          <= 3'd0;
      pos          <= 6'd0;
      lane         <= 3'd0;
    end else begin
      byte_vld_d <= (state == ST_FILL);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.func)
              FUNC_WRITE: begin
                if (wr_in_range) begin
                  state <= ST_WR_MOD;
                end
              end
              FUNC_PAGE, FUNC_INIT: begin
                init_run <= (item.func == FUNC_INIT);
                rep      <= 3'd0;
                pos      <= 6'd0;
                lane     <= 3'd0;
                state    <= ST_FILL;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WR_MOD: begin
          state <= ST_IDLE;
        end
        ST_FILL: begin
          pos  <= pos + 6'd1;
          lane <= lane + 3'd1;
          if (word_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (load) begin
            lane <= 3'd0;
            if (run_end) begin
              state <= ST_IDLE;
              if (!init_run) begin
                page_counter <= page_counter + 5'd1;
              end
            end else begin
              if (rep_end) begin
                rep <= rep + 3'd1;
                pos <= 6'd0;
              end
              state <= ST_FILL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Pixel write operands, held for the write-back cycle.
  always_ff @(posedge clk) begin
    if (wr_issue) begin
      wr_addr <= {item.pixel_x[XW-1:0], item.pixel_y[5:3]};
      wr_bit  <= item.pixel_y[2:0];
      wr_on   <= item.pixel_on;
    end
  end

  // Word assembly: bytes land one lane at a time, unused lanes stay zero.
  always_ff @(posedge clk) begin
    if (accept || (state == ST_PUSH && load)) begin
      asm_word <= 64'd0;
    end else if (byte_vld_d) begin
      asm_word[{lane_d, 3'b000} +: 8] <= byte_data;
    end
    if (state == ST_FILL) begin
      lane_d    <= lane;
      word_fill <= {1'b0, lane} + 4'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && load) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && load) begin
      out_word     <= asm_word;
      out_bytes    <= word_fill;
      out_last_rep <= rep_end;
      out_last_run <= run_end;
    end
  end

  assign report.valid          = out_valid;
  assign report.report_word    = out_word;
  assign report.word_bytes     = out_bytes;
  assign report.last_of_report = out_last_rep;
  assign report.last_of_run    = out_last_run;

endmodule

// ===== rtl/core/lpr_pixel_ram.sv =====
// ----------------------------------------------------------------------------
// lpr_pixel_ram
// Pixel store: one byte per column and page, bit b is row page*8+b.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpr_pixel_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lpr_byte_unit.sv =====
// ----------------------------------------------------------------------------
// lpr_byte_unit
// Turns a run position into a report byte. Column bytes are read from the
// pixel store and masked for columns and rows outside the display.
// ----------------------------------------------------------------------------
module lpr_byte_unit #(
  parameter int DISPLAY_WIDTH  = 256,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int AW             = $clog2(DISPLAY_WIDTH * 8)
) (
  input  logic              clk,
  input  logic              issue,
  input  lpr_pkg::byte_sel_t sel,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic [7:0]        byte_data
);
  import lpr_pkg::*;

  localparam int XW = AW - 3;

  byte_req_t  req;
  logic [7:0] col_x;
  logic       col_ok;
  logic [7:0] row_mask;

  logic       s1_is_col;
  logic       s1_col_ok;
  logic [7:0] s1_value;
  logic [7:0] s1_mask;

  // Decode the byte and form the store address of its column.
  always_comb begin
    req     = report_byte(sel);
    col_x   = {sel.cs, req.col};
    col_ok  = req.is_col && ({1'b0, col_x} < 9'(DISPLAY_WIDTH));
    rd_en   = issue && col_ok;
    rd_addr = {col_x[XW-1:0], sel.page};
  end

  // Rows past the display height read as zero.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      row_mask[b] = {1'b0, sel.page, 3'(b)} < 7'(DISPLAY_HEIGHT);
    end
  end

  // Hold the decode while the store read is in flight.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_is_col <= req.is_col;
      s1_col_ok <= col_ok;
      s1_value  <= req.value;
      s1_mask   <= row_mask;
    end
  end

  // Finished byte, valid the cycle after issue.
  always_comb begin
    if (!s1_is_col) begin
      byte_data = s1_value;
    end else if (s1_col_ok) begin
      byte_data = rd_data & s1_mask;
    end else begin
      byte_data = 8'h00;
    end
  end

endmodule
